FILE: design/sre_pkg.sv
// Package for the spotlight radiance evaluator: constants, register codes.
`timescale 1ns / 1ps
package sre_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// pipeline depths of the iterative sections
	localparam int SQRT_STEPS = 25;
	localparam int COS_STEPS  = 15;
	localparam int T_STEPS    = 16;
	localparam int OUT_STEPS  = 16;

	localparam logic [29:0] INV2PI_Q32 = 30'd683565276;
	localparam logic [14:0] ONE_Q14    = 15'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_POSITION = 3'd0,
		REG_LIGHT_AXIS     = 3'd1,
		REG_LIGHT_POWER    = 3'd2,
		REG_COS_OUTER      = 3'd3,
		REG_COS_INNER      = 3'd4
	} cfg_reg_t;

endpackage

FILE: design/spotlight_radiance_eval_top.sv
// Spotlight radiance evaluator: fully pipelined, one point per cycle while the output is not stalled.
// The pipeline is mostly made up of the 25-stage square root, 15-stage cosine divide, 16-stage
// ramp divide and 16-stage output divide, each resolving one bit per stage.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (arst_n low) clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
module spotlight_radiance_eval_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sre_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sre_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [15:0]              point_x,
	input  logic signed [15:0]              point_y,
	input  logic signed [15:0]              point_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [15:0]                     red,
	output logic [15:0]                     green,
	output logic [15:0]                     blue,
	output logic                            saturated
);
	import sre_pkg::*;

	// configuration
	logic [47:0]        light_position_q, light_axis_q, light_power_q;
	logic signed [15:0] cos_outer_q, cos_inner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_position_q <= '0;
			light_axis_q     <= 48'd16384;
			light_power_q    <= '0;
			cos_outer_q      <= '0;
			cos_inner_q      <= 16'sd16384;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIGHT_POSITION: light_position_q <= cfg_data;
				REG_LIGHT_AXIS:     light_axis_q     <= cfg_data;
				REG_LIGHT_POWER:    light_power_q    <= cfg_data;
				REG_COS_OUTER:      cos_outer_q      <= cfg_data[15:0];
				REG_COS_INNER:      cos_inner_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic signed [17:0] den;
	logic [16:0]        den_u;
	assign den   = 18'sd32768 - 18'(cos_outer_q) - 18'(cos_inner_q);
	assign den_u = den[16:0];

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// S1: offset from light
	logic               v_s1;
	logic signed [16:0] d_s1 [0:2];
	logic signed [15:0] pt [0:2];
	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= 17'(pt[k]) - 17'($signed(light_position_q[16*k +: 16]));
			end
		end
	end

	// S2: squares and axis products
	logic               v_s2;
	logic [32:0]        sq_s2 [0:2];
	logic signed [32:0] pr_s2 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		logic signed [33:0] sq;
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq        = d_s1[k] * d_s1[k];
				sq_s2[k] <= sq[32:0];
				pr_s2[k] <= d_s1[k] * $signed(light_axis_q[16*k +: 16]);
			end
		end
	end

	// S3 and square root stages: index 0 is S3
	logic        rv_s    [0:SQRT_STEPS];
	logic [50:0] rx_s    [0:SQRT_STEPS];
	logic [50:0] rr_s    [0:SQRT_STEPS];
	logic [33:0] rdsq_s  [0:SQRT_STEPS];
	logic [33:0] rmag_s  [0:SQRT_STEPS];
	logic        rneg_s  [0:SQRT_STEPS];
	logic        rspec_s [0:SQRT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s[0] <= 1'b0;
		else if (en) rv_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		logic [33:0]        dsq;
		logic signed [34:0] dot;
		logic [34:0]        mag;
		if (en) begin
			dsq = 34'(sq_s2[0]) + 34'(sq_s2[1]) + 34'(sq_s2[2]);
			dot = 35'(pr_s2[0]) + 35'(pr_s2[1]) + 35'(pr_s2[2]);
			mag = dot[34] ? 35'(-dot) : dot;
			rx_s[0]    <= {1'b0, dsq, 16'b0};
			rr_s[0]    <= '0;
			rdsq_s[0]  <= dsq;
			rmag_s[0]  <= mag[33:0];
			rneg_s[0]  <= dot[34];
			rspec_s[0] <= (dsq == '0) || (den <= 18'sd0);
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [50:0] B = 51'(1) << (2 * (SQRT_STEPS - 1 - j));
		logic [50:0] trial;
		assign trial = rr_s[j] + B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[j+1] <= 1'b0;
			else if (en) rv_s[j+1] <= rv_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rx_s[j] >= trial) begin
					rx_s[j+1] <= rx_s[j] - trial;
					rr_s[j+1] <= (rr_s[j] >> 1) + B;
				end else begin
					rx_s[j+1] <= rx_s[j];
					rr_s[j+1] <= rr_s[j] >> 1;
				end
				rdsq_s[j+1]  <= rdsq_s[j];
				rmag_s[j+1]  <= rmag_s[j];
				rneg_s[j+1]  <= rneg_s[j];
				rspec_s[j+1] <= rspec_s[j];
			end
		end
	end

	// cosine divide: index 0 holds the overflow check
	logic        cv_s    [0:COS_STEPS];
	logic [37:0] crem_s  [0:COS_STEPS];
	logic [24:0] clen_s  [0:COS_STEPS];
	logic [14:0] cq_s    [0:COS_STEPS];
	logic        covf_s  [0:COS_STEPS];
	logic        cneg_s  [0:COS_STEPS];
	logic        cspec_s [0:COS_STEPS];
	logic [33:0] cdsq_s  [0:COS_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_s[0] <= 1'b0;
		else if (en) cv_s[0] <= rv_s[SQRT_STEPS];
	end

	always_ff @(posedge clk) begin
		logic [37:0] num;
		logic [24:0] len;
		if (en) begin
			num = {rmag_s[SQRT_STEPS], 4'b0};
			len = rr_s[SQRT_STEPS][24:0];
			crem_s[0]  <= num;
			clen_s[0]  <= len;
			cq_s[0]    <= '0;
			covf_s[0]  <= {2'b0, num} >= {len, 15'b0};
			cneg_s[0]  <= rneg_s[SQRT_STEPS];
			cspec_s[0] <= rspec_s[SQRT_STEPS];
			cdsq_s[0]  <= rdsq_s[SQRT_STEPS];
		end
	end

	for (genvar j = 0; j < COS_STEPS; j++) begin : g_cdiv
		logic [39:0] sh;
		logic        take;
		assign sh   = {15'b0, clen_s[j]} << (COS_STEPS - 1 - j);
		assign take = {2'b0, crem_s[j]} >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_s[j+1] <= 1'b0;
			else if (en) cv_s[j+1] <= cv_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				crem_s[j+1]  <= take ? crem_s[j] - sh[37:0] : crem_s[j];
				cq_s[j+1]    <= {cq_s[j][13:0], take};
				clen_s[j+1]  <= clen_s[j];
				covf_s[j+1]  <= covf_s[j];
				cneg_s[j+1]  <= cneg_s[j];
				cspec_s[j+1] <= cspec_s[j];
				cdsq_s[j+1]  <= cdsq_s[j];
			end
		end
	end

	// cosine, cone zone and ramp operands; index 0 of the ramp divide
	logic        tv_s    [0:T_STEPS];
	logic [32:0] trem_s  [0:T_STEPS];
	logic [16:0] td_s    [0:T_STEPS];
	logic [15:0] tq_s    [0:T_STEPS];
	logic        tzero_s [0:T_STEPS];
	logic        tfull_s [0:T_STEPS];
	logic        tspec_s [0:T_STEPS];
	logic [33:0] tdsq_s  [0:T_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tv_s[0] <= 1'b0;
		else if (en) tv_s[0] <= cv_s[COS_STEPS];
	end

	always_ff @(posedge clk) begin
		logic [14:0]        q;
		logic [14:0]        cmag;
		logic signed [15:0] c;
		logic [16:0]        tn;
		if (en) begin
			q    = cq_s[COS_STEPS];
			cmag = (covf_s[COS_STEPS] || q > ONE_Q14) ? ONE_Q14 : q;
			c    = cneg_s[COS_STEPS] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
			tn   = 17'(c) - 17'(cos_outer_q);
			trem_s[0]  <= {tn, 16'b0};
			td_s[0]    <= 17'(cos_inner_q) - 17'(cos_outer_q);
			tq_s[0]    <= '0;
			tzero_s[0] <= c < cos_outer_q;
			tfull_s[0] <= c >= cos_inner_q;
			tspec_s[0] <= cspec_s[COS_STEPS];
			tdsq_s[0]  <= cdsq_s[COS_STEPS];
		end
	end

	for (genvar j = 0; j < T_STEPS; j++) begin : g_tdiv
		logic [32:0] sh;
		logic        take;
		assign sh   = {16'b0, td_s[j]} << (T_STEPS - 1 - j);
		assign take = trem_s[j] >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tv_s[j+1] <= 1'b0;
			else if (en) tv_s[j+1] <= tv_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				trem_s[j+1]  <= take ? trem_s[j] - sh : trem_s[j];
				tq_s[j+1]    <= {tq_s[j][14:0], take};
				td_s[j+1]    <= td_s[j];
				tzero_s[j+1] <= tzero_s[j];
				tfull_s[j+1] <= tfull_s[j];
				tspec_s[j+1] <= tspec_s[j];
				tdsq_s[j+1]  <= tdsq_s[j];
			end
		end
	end

	// t^2, then weight t^4
	logic        v_s4, v_s5;
	logic [31:0] t2m_s4;
	logic        zero_s4, full_s4, spec_s4, spec_s5;
	logic [33:0] dsq_s4, dsq_s5;
	logic [16:0] w_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= tv_s[T_STEPS];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] w4;
		if (en) begin
			t2m_s4  <= tq_s[T_STEPS] * tq_s[T_STEPS];
			zero_s4 <= tzero_s[T_STEPS];
			full_s4 <= tfull_s[T_STEPS];
			spec_s4 <= tspec_s[T_STEPS];
			dsq_s4  <= tdsq_s[T_STEPS];

			w4 = t2m_s4[31:16] * t2m_s4[31:16];
			if (zero_s4)      w_s5 <= '0;
			else if (full_s4) w_s5 <= 17'h10000;
			else              w_s5 <= {1'b0, w4[31:16]};
			spec_s5 <= spec_s4;
			dsq_s5  <= dsq_s4;
		end
	end

	// power times weight, divisor partial products
	logic        v_s6, v_s7, v_s8;
	logic [32:0] a_s6 [0:2];
	logic [33:0] dpl_s6, dph_s6;
	logic        spec_s6, spec_s7, spec_s8;
	logic [61:0] p_s7 [0:2];
	logic        a32_s7 [0:2];
	logic [50:0] dv_s7, dv_s8;
	logic [62:0] n_s8 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a_s6[k]   <= light_power_q[16*k +: 16] * w_s5;
				p_s7[k]   <= a_s6[k][31:0] * INV2PI_Q32;
				a32_s7[k] <= a_s6[k][32];
				n_s8[k]   <= 63'(p_s7[k]) + (a32_s7[k] ? {1'b0, INV2PI_Q32, 32'b0} : 63'd0);
			end
			dpl_s6  <= den_u * dsq_s5[16:0];
			dph_s6  <= den_u * dsq_s5[33:17];
			spec_s6 <= spec_s5;
			dv_s7   <= 51'(dpl_s6) + {dph_s6, 17'b0};
			spec_s7 <= spec_s6;
			dv_s8   <= dv_s7;
			spec_s8 <= spec_s7;
		end
	end

	// output divide: index 0 holds the overflow check
	logic        ov_s    [0:OUT_STEPS];
	logic [62:0] orem_s  [0:OUT_STEPS][0:2];
	logic [15:0] oq_s    [0:OUT_STEPS][0:2];
	logic        oovf_s  [0:OUT_STEPS][0:2];
	logic [50:0] odv_s   [0:OUT_STEPS];
	logic        ospec_s [0:OUT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_s[0] <= 1'b0;
		else if (en) ov_s[0] <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				orem_s[0][k] <= n_s8[k];
				oq_s[0][k]   <= '0;
				oovf_s[0][k] <= {21'b0, n_s8[k]} >= {dv_s8, 33'b0};
			end
			odv_s[0]   <= dv_s8;
			ospec_s[0] <= spec_s8;
		end
	end

	for (genvar j = 0; j < OUT_STEPS; j++) begin : g_odiv
		logic [83:0] sh;
		assign sh = {33'b0, odv_s[j]} << (17 + OUT_STEPS - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ov_s[j+1] <= 1'b0;
			else if (en) ov_s[j+1] <= ov_s[j];
		end

		always_ff @(posedge clk) begin
			logic take;
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					take = {21'b0, orem_s[j][k]} >= sh;
					orem_s[j+1][k] <= take ? orem_s[j][k] - sh[62:0] : orem_s[j][k];
					oq_s[j+1][k]   <= {oq_s[j][k][14:0], take};
					oovf_s[j+1][k] <= oovf_s[j][k];
				end
				odv_s[j+1]   <= odv_s[j];
				ospec_s[j+1] <= ospec_s[j];
			end
		end
	end

	// output register
	logic [15:0] ch [0:2];
	logic        any_ovf;

	always_comb begin
		any_ovf = 1'b0;
		for (int k = 0; k < 3; k++) begin
			ch[k] = (ospec_s[OUT_STEPS] || oovf_s[OUT_STEPS][k]) ? 16'hFFFF
				: oq_s[OUT_STEPS][k];
			any_ovf = any_ovf | oovf_s[OUT_STEPS][k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= ov_s[OUT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red       <= ch[0];
			green     <= ch[1];
			blue      <= ch[2];
			saturated <= ospec_s[OUT_STEPS] | any_ovf;
		end
	end

endmodule

FILE: tb/spotlight_radiance_eval_top_tb.sv
// Self-checking testbench for the spotlight radiance evaluator.
`timescale 1ns / 1ps
module spotlight_radiance_eval_top_tb;
	import sre_pkg::*;

	localparam int LATENCY = 84;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint INV2PI = 683565276;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} point_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        sat;
	} radiance_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] point_x = 0, point_y = 0, point_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [15:0] red, green, blue;
	logic saturated;

	// light settings as the predictor sees them
	logic [47:0] light_pos = 48'd0;
	logic [47:0] light_dir = 48'd16384;
	logic [47:0] light_pow = 48'd0;
	logic signed [15:0] cos_out = 16'sd0;
	logic signed [15:0] cos_in = 16'sd16384;

	point_t pending_points[$];
	radiance_t expected_radiance[$];
	int errors = 0;
	int checked = 0;
	int saturated_seen = 0;
	longint cycles = 0;
	int hold_off = 0;

	always #1 clk = ~clk;

	spotlight_radiance_eval_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready), .red(red), .green(green),
		.blue(blue), .saturated(saturated)
	);

	function automatic longint lane_s(logic [47:0] packed_v, int k);
		logic signed [15:0] v;
		v = packed_v[16*k +: 16];
		return longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned val);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > val) bitv >>= 2;
		while (bitv != 0) begin
			if (val >= root + bitv) begin
				val -= root + bitv;
				root = (root >> 1) + bitv;
			end else
				root >>= 1;
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic radiance_t spot_radiance(point_t p);
		radiance_t r;
		longint d[3];
		longint dot_p, co, ci, den, c;
		longint unsigned dsq, len, mag, q, w, t, t2, a;
		logic [127:0] num, ch;
		longint pk[3];
		pk[0] = p.x; pk[1] = p.y; pk[2] = p.z;
		co = cos_out;
		ci = cos_in;
		den = 32768 - co - ci;
		dsq = 0;
		dot_p = 0;
		for (int k = 0; k < 3; k++) begin
			d[k] = pk[k] - lane_s(light_pos, k);
			dsq += d[k] * d[k];
			dot_p += d[k] * lane_s(light_dir, k);
		end
		if (dsq == 0 || den <= 0) begin
			r = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
			return r;
		end
		len = int_sqrt(dsq << 16);
		mag = dot_p < 0 ? -dot_p : dot_p;
		q = (mag << 4) / len;
		if (q > 16384) q = 16384;
		c = dot_p < 0 ? -longint'(q) : longint'(q);
		if (c < co) w = 0;
		else if (c >= ci) w = 65536;
		else begin
			t = ((c - co) << 16) / (ci - co);
			t2 = (t * t) >> 16;
			w = (t2 * t2) >> 16;
		end
		r.sat = 0;
		for (int k = 0; k < 3; k++) begin
			a = light_pow[16*k +: 16] * w;
			num = 128'(a) * 128'(INV2PI);
			ch = (num / (128'(den) * 128'(dsq))) >> 17;
			if (ch > 65535) begin
				ch = 65535;
				r.sat = 1;
			end
			case (k)
				0: r.red = ch[15:0];
				1: r.green = ch[15:0];
				default: r.blue = ch[15:0];
			endcase
		end
		return r;
	endfunction

	// sender: holds the item until accepted, then a random gap
	int in_gap = 0;
	bit in_acc = 0;
	always @(negedge clk) begin
		if (arst_n && (in_acc || !in_valid)) begin
			if (in_acc)
				in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 0;
			end else if (pending_points.size() > 0) begin
				in_valid <= 1;
				point_x <= pending_points[0].x;
				point_y <= pending_points[0].y;
				point_z <= pending_points[0].z;
			end else
				in_valid <= 0;
		end
	end

	// predict on acceptance
	always @(posedge clk) begin
		in_acc <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			expected_radiance.push_back(spot_radiance(pending_points.pop_front()));
		end
	end

	// receiver stall pattern, with a long hold-off when requested
	int out_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				if (out_valid && out_ready)
					out_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		radiance_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{red, green, blue, saturated};
			if (expected_radiance.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected item: %p", got);
			end else begin
				want = expected_radiance.pop_front();
				checked++;
				if (want.sat) saturated_seen++;
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_LIGHT_POSITION: light_pos = val;
			REG_LIGHT_AXIS:     light_dir = val;
			REG_LIGHT_POWER:    light_pow = val;
			REG_COS_OUTER:      cos_out = val[15:0];
			default:            cos_in = val[15:0];
		endcase
	endtask

	task automatic wait_idle();
		while (pending_points.size() > 0 || in_valid || expected_radiance.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom), 16'($urandom), 16'($urandom)};
	endfunction

	function automatic logic [47:0] pack3(int a, int b, int c);
		return {16'(c), 16'(b), 16'(a)};
	endfunction

	// point near the light, with occasional full-range coordinates
	function automatic point_t near_point(int spread);
		point_t p;
		p.x = 16'(lane_s(light_pos, 0) + $signed($urandom_range(0, 2 * spread)) - spread);
		p.y = 16'(lane_s(light_pos, 1) + $signed($urandom_range(0, 2 * spread)) - spread);
		p.z = 16'(lane_s(light_pos, 2) + $signed($urandom_range(0, 2 * spread)) - spread);
		if ($urandom_range(0, 9) == 0) p = {16'($urandom), 16'($urandom), 16'($urandom)};
		return p;
	endfunction

	initial begin
		int cos_pick;
		point_t pt;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset settings, zero distance, coordinate extremes
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0});
		pending_points.push_back('{16'sd256, 16'sd0, 16'sd0});
		pending_points.push_back('{-16'sd256, 16'sd0, 16'sd0});
		wait_idle();
		write_reg(REG_LIGHT_POWER, pack3(16'hFFFF, 256, 1));
		write_reg(REG_COS_OUTER, 16'(8192));
		write_reg(REG_COS_INNER, 16'(15000));
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0});
		pending_points.push_back('{16'sd1, 16'sd0, 16'sd0});
		pending_points.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		pending_points.push_back('{-16'sh8000, -16'sh8000, -16'sh8000});
		pending_points.push_back('{16'sh7FFF, -16'sh8000, 16'sd0});
		pending_points.push_back('{16'sd512, 16'sd300, 16'sd0});
		pending_points.push_back('{16'sd512, 16'sd100, 16'sd0});
		pending_points.push_back('{16'sd0, 16'sd512, 16'sd0});
		wait_idle();
		// non-unit axis, non-positive divisor, extreme cosines
		write_reg(REG_LIGHT_AXIS, pack3(32767, 32767, -32768));
		write_reg(REG_LIGHT_POSITION, pack3(-32768, 32767, 100));
		pending_points.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		pending_points.push_back('{-16'sh8000, -16'sh8000, 16'sd0});
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0});
		wait_idle();
		write_reg(REG_COS_OUTER, 16'(16384));
		write_reg(REG_COS_INNER, 16'(16384));
		pending_points.push_back('{16'sd5, 16'sd5, 16'sd5});
		wait_idle();
		write_reg(REG_COS_OUTER, 16'(-16384));
		write_reg(REG_COS_INNER, 16'(-16384));
		pending_points.push_back('{16'sd5, 16'sd5, 16'sd5});
		pending_points.push_back('{-16'sd5, 16'sd5, 16'sd5});
		wait_idle();
		write_reg(REG_COS_INNER, 16'(16384));
		write_reg(REG_LIGHT_POSITION, 48'hFFFF_FFFF_FFFF);
		pending_points.push_back('{-16'sd1, -16'sd1, -16'sd1});
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0});
		wait_idle();

		// random phases with new light settings each time
		for (int ph = 0; ph < 11; ph++) begin
			if (ph == 0) write_reg(REG_LIGHT_POSITION, 48'd0);
			else write_reg(REG_LIGHT_POSITION,
				pack3($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
					$urandom_range(0, 4000) - 2000));
			case (ph % 3)
				0: write_reg(REG_LIGHT_AXIS, pack3(16384, 0, 0));
				1: write_reg(REG_LIGHT_AXIS, pack3(0, -16384, 0));
				default: write_reg(REG_LIGHT_AXIS, rand48());
			endcase
			write_reg(REG_LIGHT_POWER, ph == 10 ? 48'hFFFF_FFFF_FFFF : rand48());
			cos_pick = $urandom_range(0, 16384);
			write_reg(REG_COS_OUTER, 16'(ph == 1 ? -16384 : cos_pick - 8192));
			write_reg(REG_COS_INNER, 16'(ph == 1 ? 16384 :
				$urandom_range(cos_pick - 8192 > 0 ? cos_pick - 8192 : 0, 16384)));
			if (ph == 4) hold_off = 400;
			for (int n = 0; n < 100; n++) begin
				pt = near_point(ph % 2 ? 300 : 4000);
				pending_points.push_back(pt);
			end
			wait_idle();
		end
		$display("checked %0d items over 11 random light settings, %0d saturated",
			checked, saturated_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/sre_pkg.sv
design/spotlight_radiance_eval_top.sv
tb/spotlight_radiance_eval_top_tb.sv
